[hdl/ardma_pkg.sv]
// ardma_pkg: shared types, constants and decode helpers for the audio RAM DMA engine.
// No dependencies; ardma_front, ardma_back and audio_ram_dma_engine import it.

package ardma_pkg;

  // Audio RAM size in bytes; must be a power of two (slot index wraps by masking).
  localparam int unsigned RAM_BYTES = 65536;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);

  // Command queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register half masks.
  localparam logic [15:0] HI_MASK = 16'h03FF;
  localparam logic [15:0] LO_MASK = 16'hFFE0;
  localparam logic [15:0] DIR_BIT = 16'h8000;

  localparam int unsigned AW26 = 26;
  localparam int unsigned AW27 = 27;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,  // zero-length start or nothing to do
    CMD_START = 2'd1,  // start with nonzero length
    CMD_ADV   = 2'd2   // advance one byte
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // One decoded item as it sits in the queue.
  typedef struct packed {
    cmd_e             cmd;
    logic             to_main;
    logic [AW26-1:0]  main_base;
    logic [AW26-1:0]  ram_base;
    logic [AW26-1:0]  length;
    logic [7:0]       data;
  } cmd_t;

  // Queue to back end handshake.
  typedef struct packed {
    logic valid;
    cmd_t entry;
  } queue_out_t;

  function automatic logic [AW26-1:0] join_halves(input logic [15:0] hi, input logic [15:0] lo);
    logic [15:0] h;
    logic [15:0] l;
    h = hi & HI_MASK;
    l = lo & LO_MASK;
    return {h[9:0], l};
  endfunction

endpackage

[hdl/ardma_ram.sv]
// ardma_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module ardma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ardma_front.sv]
// ardma_front: accepts input items, decodes register halves and classifies the
// command, then holds it in a short queue for the back end. Uses ardma_pkg.

module ardma_front import ardma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] mm_hi_i,
  input  logic [15:0] mm_lo_i,
  input  logic [15:0] ar_hi_i,
  input  logic [15:0] ar_lo_i,
  input  logic [15:0] len_hi_i,
  input  logic [15:0] len_lo_i,
  input  logic [7:0]  main_data_i,
  output queue_out_t  queue_o,
  input  logic        pop_i
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic              full;
  logic              push;
  cmd_t              dec;
  logic [AW26-1:0]   dec_len;

  // decode
  always_comb begin
    dec_len       = join_halves(len_hi_i, len_lo_i);
    dec.main_base = join_halves(mm_hi_i, mm_lo_i);
    dec.ram_base  = join_halves(ar_hi_i, ar_lo_i);
    dec.length    = dec_len;
    dec.to_main   = (len_hi_i & DIR_BIT) != '0;
    dec.data      = main_data_i;
    if (op_i) begin
      dec.cmd = CMD_ADV;
    end else if (dec_len != '0) begin
      dec.cmd = CMD_START;
    end else begin
      dec.cmd = CMD_NOP;
    end
  end

  assign full       = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

  assign queue_o.valid = cnt_q != '0;
  assign queue_o.entry = entry_q[rd_ptr_q];

endmodule

[hdl/ardma_back.sv]
// ardma_back: executes queued commands one per cycle while the output register is
// empty or being taken: transfer state, request generation, audio RAM access,
// completion counters and the output register. Uses ardma_pkg and ardma_ram.

module ardma_back import ardma_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  queue_out_t   queue_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   kind_o,
  output logic [26:0]  main_address_o,
  output logic [7:0]   byte_out_o,
  output logic         last_o,
  output logic [31:0]  transfers_to_main_o,
  output logic [31:0]  transfers_from_main_o,
  output logic [47:0]  bytes_to_main_o,
  output logic [47:0]  bytes_from_main_o,
  output logic [25:0]  lowest_loaded_o,
  output logic [26:0]  highest_loaded_end_o
);

  // transfer state
  logic            busy_q, busy_d;
  logic            dir_q, dir_d;
  logic [AW26-1:0] mbase_q, mbase_d;
  logic [AW26-1:0] rbase_q, rbase_d;
  logic [AW26-1:0] len_q, len_d;
  logic [AW26-1:0] idx_q, idx_d;
  logic [31:0]     cnt_to_q, cnt_to_d;
  logic [31:0]     cnt_from_q, cnt_from_d;
  logic [47:0]     tot_to_q, tot_to_d;
  logic [47:0]     tot_from_q, tot_from_d;
  logic [AW26-1:0] low_q, low_d;
  logic [AW27-1:0] high_q, high_d;

  // output register
  logic            out_valid_q, out_valid_d;
  kind_e           kind_q, kind_d;
  logic [AW27-1:0] addr_q, addr_d;
  logic            last_q, last_d;

  cmd_t            e;
  logic            exec;
  logic            is_start, is_adv, done, issue;
  logic            sel_dir;
  logic [AW26-1:0] sel_mbase, sel_rbase, sel_len;
  logic [AW26-1:0] idx_inc, req_idx;
  logic [AW27-1:0] req_addr;
  logic            req_last;
  logic [AW27-1:0] load_end;
  logic            ram_we, ram_re;
  logic [RAM_AW-1:0] wr_slot, rd_slot;
  logic [7:0]      ram_rdata;

  assign e        = queue_i.entry;
  assign exec     = queue_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o    = exec;

  assign is_start = e.cmd == CMD_START;
  assign is_adv   = (e.cmd == CMD_ADV) && busy_q;
  assign idx_inc  = idx_q + 1'b1;
  assign done     = is_adv && (idx_inc >= len_q);
  assign issue    = is_start || (is_adv && !done);

  assign sel_dir   = is_start ? e.to_main   : dir_q;
  assign sel_mbase = is_start ? e.main_base : mbase_q;
  assign sel_rbase = is_start ? e.ram_base  : rbase_q;
  assign sel_len   = is_start ? e.length    : len_q;
  assign req_idx   = is_start ? '0          : idx_inc;

  assign req_addr = {1'b0, sel_mbase} + {1'b0, req_idx};
  assign req_last = ({1'b0, req_idx} + AW27'(1)) == {1'b0, sel_len};
  assign load_end = {1'b0, rbase_q} + {1'b0, len_q};

  // audio RAM: loads write the current byte, stores read the requested one
  assign ram_we  = exec && is_adv && !dir_q;
  assign wr_slot = rbase_q[RAM_AW-1:0] + idx_q[RAM_AW-1:0];
  assign ram_re  = exec && issue && sel_dir;
  assign rd_slot = sel_rbase[RAM_AW-1:0] + req_idx[RAM_AW-1:0];

  ardma_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot),
    .wdata_i (e.data),
    .re_i    (ram_re),
    .raddr_i (rd_slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    busy_d     = busy_q;
    dir_d      = dir_q;
    mbase_d    = mbase_q;
    rbase_d    = rbase_q;
    len_d      = len_q;
    idx_d      = idx_q;
    cnt_to_d   = cnt_to_q;
    cnt_from_d = cnt_from_q;
    tot_to_d   = tot_to_q;
    tot_from_d = tot_from_q;
    low_d      = low_q;
    high_d     = high_q;
    if (exec && is_start) begin
      busy_d  = 1'b1;
      dir_d   = e.to_main;
      mbase_d = e.main_base;
      rbase_d = e.ram_base;
      len_d   = e.length;
      idx_d   = '0;
    end else if (exec && is_adv) begin
      idx_d = idx_inc;
      if (done) begin
        busy_d = 1'b0;
        if (dir_q) begin
          cnt_to_d = cnt_to_q + 1'b1;
          tot_to_d = tot_to_q + 48'(len_q);
        end else begin
          if (cnt_from_q == '0 || rbase_q < low_q) begin
            low_d = rbase_q;
          end
          if (load_end > high_q) begin
            high_d = load_end;
          end
          cnt_from_d = cnt_from_q + 1'b1;
          tot_from_d = tot_from_q + 48'(len_q);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    last_d      = last_q;
    if (exec) begin
      out_valid_d = 1'b1;
      if (issue) begin
        kind_d = sel_dir ? KIND_WRITE : KIND_READ;
        addr_d = req_addr;
        last_d = req_last;
      end else begin
        kind_d = KIND_NONE;
        addr_d = '0;
        last_d = 1'b0;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      dir_q       <= 1'b0;
      mbase_q     <= '0;
      rbase_q     <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      cnt_to_q    <= '0;
      cnt_from_q  <= '0;
      tot_to_q    <= '0;
      tot_from_q  <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      dir_q       <= dir_d;
      mbase_q     <= mbase_d;
      rbase_q     <= rbase_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      cnt_to_q    <= cnt_to_d;
      cnt_from_q  <= cnt_from_d;
      tot_to_q    <= tot_to_d;
      tot_from_q  <= tot_from_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    last_q <= last_d;
  end

  // RAM read data lands together with the output register and holds while stalled
  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign main_address_o = addr_q;
  assign byte_out_o     = (kind_q == KIND_WRITE) ? ram_rdata : 8'd0;
  assign last_o         = last_q;

  // state only changes on the next execute, so it is the state after the shown step
  assign transfers_to_main_o   = cnt_to_q;
  assign transfers_from_main_o = cnt_from_q;
  assign bytes_to_main_o       = tot_to_q;
  assign bytes_from_main_o     = tot_from_q;
  assign lowest_loaded_o       = low_q;
  assign highest_loaded_end_o  = high_q;

endmodule

[hdl/audio_ram_dma_engine.sv]
// audio_ram_dma_engine: top level of the byte-serial DMA engine between main
// memory and the internal audio RAM. Uses ardma_pkg, ardma_front, ardma_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | op, mm/ar/len halves, main_data
//  out     | out_valid_o/out_stall_i | kind, main_address, byte_out, last, counters
//
// One item per cycle sustained while the output is not stalled; an item's result
// passes the queue register, then the output register with the audio RAM read,
// before it shows on the output and transfers.
// The back end executes a queued item whenever the output register is empty or
// being taken; the two-entry queue lets the input keep flowing during short stalls.
// Reset clears transfer state, counters and queue; audio RAM contents stay undefined.

module audio_ram_dma_engine import ardma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] mm_hi_i,
  input  logic [15:0] mm_lo_i,
  input  logic [15:0] ar_hi_i,
  input  logic [15:0] ar_lo_i,
  input  logic [15:0] len_hi_i,
  input  logic [15:0] len_lo_i,
  input  logic [7:0]  main_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [26:0] main_address_o,
  output logic [7:0]  byte_out_o,
  output logic        last_o,
  output logic [31:0] transfers_to_main_o,
  output logic [31:0] transfers_from_main_o,
  output logic [47:0] bytes_to_main_o,
  output logic [47:0] bytes_from_main_o,
  output logic [25:0] lowest_loaded_o,
  output logic [26:0] highest_loaded_end_o
);

  queue_out_t queue;  // decoded command at the head of the queue
  logic       pop;    // back end takes the head this cycle

  // front: decode register halves, classify start / empty start / advance
  ardma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .mm_hi_i     (mm_hi_i),
    .mm_lo_i     (mm_lo_i),
    .ar_hi_i     (ar_hi_i),
    .ar_lo_i     (ar_lo_i),
    .len_hi_i    (len_hi_i),
    .len_lo_i    (len_lo_i),
    .main_data_i (main_data_i),
    .queue_o     (queue),
    .pop_i       (pop)
  );

  // back: transfer sequencing, audio RAM, completion bookkeeping
  ardma_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .queue_i               (queue),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .kind_o                (kind_o),
    .main_address_o        (main_address_o),
    .byte_out_o            (byte_out_o),
    .last_o                (last_o),
    .transfers_to_main_o   (transfers_to_main_o),
    .transfers_from_main_o (transfers_from_main_o),
    .bytes_to_main_o       (bytes_to_main_o),
    .bytes_from_main_o     (bytes_from_main_o),
    .lowest_loaded_o       (lowest_loaded_o),
    .highest_loaded_end_o  (highest_loaded_end_o)
  );

endmodule
